### sv/itp_pkg.sv
// shared types, constants and character helpers for the infix to postfix converter
// no dependencies

`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NONE   = 8'h00;

    localparam logic [1:0] PREC_POW  = 2'd3;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_NONE = 2'd0;

    typedef enum logic [1:0] {
        CL_LETTER,
        CL_LPAREN,
        CL_RPAREN,
        CL_OPER
    } t_class;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNMATCHED = 2'd2
    } t_status;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [7:0] ch;
        t_class     cls;
        logic [1:0] prec;
        logic       eoi;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        t_status    status;
    } t_result;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        unique case (c) inside
            CH_DOLLAR, CH_CARET: p = PREC_POW;
            CH_STAR, CH_SLASH:   p = PREC_MUL;
            CH_PLUS, CH_MINUS:   p = PREC_ADD;
            default:             p = PREC_NONE;
        endcase
        return p;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

### sv/infix_to_postfix_converter.sv
// top level of the infix to postfix converter: front end, item queue and back end
// depends on itp_pkg, itp_front, itp_queue, itp_back

`timescale 1ns / 1ps

// Shunting-yard converter: one infix character per input transaction, one postfix
// character (or a bare end or error marker) per output transaction, with
// last_of_run set on the final result of each input. A two-entry queue lets
// input be taken while the back end works. The back end emits each letter, pushes
// operators and '(', pops stacked operators on ')', on an incoming operator of
// equal or lower precedence and in the flush at end of expression, discards the
// matching '(' and emits error markers. When an item that produced two or more
// results ends on a result of its own, the held final result goes out before the
// next item is taken.
// The operator stack holds 32 entries; a push onto a full stack drops the
// character, reports overflow and clears the stack.

module infix_to_postfix_converter import itp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_in_end_of_expr,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_has_char,
    output logic       o_out_last_of_run,
    output logic [1:0] o_out_status
);

    logic  w_q_full;
    logic  w_wr_en;
    t_item w_wr_item;
    logic  w_rd_en;
    t_head w_head;

    itp_front u_front (
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_char        (i_in_char),
        .i_in_end_of_expr (i_in_end_of_expr),
        .i_q_full         (w_q_full),
        .o_wr_en          (w_wr_en),
        .o_wr_item        (w_wr_item)
    );

    itp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_item (w_wr_item),
        .o_full    (w_q_full),
        .i_rd_en   (w_rd_en),
        .o_head    (w_head)
    );

    itp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (w_head),
        .o_rd_en           (w_rd_en),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_char        (o_out_char),
        .o_out_has_char    (o_out_has_char),
        .o_out_last_of_run (o_out_last_of_run),
        .o_out_status      (o_out_status)
    );

    // error markers carry no character and end the run
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status != STAT_OK)) |-> (o_out_last_of_run && !o_out_has_char))
        else $error("error marker not a bare final result");

    a_bare_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_has_char) |-> (o_out_char == CH_NONE))
        else $error("marker carries a character");

    a_deq_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> w_head.valid)
        else $error("back end finished an item that was not in the queue");

endmodule

### sv/itp_front.sv
// front end: accepts input characters, classifies them and writes them to the queue
// depends on itp_pkg

`timescale 1ns / 1ps

module itp_front import itp_pkg::*; (
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_in_end_of_expr,
    input  logic       i_q_full,
    output logic       o_wr_en,
    output t_item      o_wr_item
);

    always_comb begin
        o_in_stall = i_q_full;
        o_wr_en    = i_in_valid && !i_q_full;
    end

    always_comb begin
        o_wr_item.ch   = i_in_char;
        o_wr_item.eoi  = i_in_end_of_expr;
        o_wr_item.prec = prec_of(i_in_char);
        if (is_letter(i_in_char)) begin
            o_wr_item.cls = CL_LETTER;
        end else if (i_in_char == CH_LPAREN) begin
            o_wr_item.cls = CL_LPAREN;
        end else if (i_in_char == CH_RPAREN) begin
            o_wr_item.cls = CL_RPAREN;
        end else begin
            o_wr_item.cls = CL_OPER;
        end
    end

endmodule

### sv/itp_queue.sv
// short queue of classified items between the front and back ends
// depends on itp_pkg

`timescale 1ns / 1ps

module itp_queue import itp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_item i_wr_item,
    output logic  o_full,
    input  logic  i_rd_en,
    output t_head o_head
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_cnt;
    logic                w_wr;
    logic                w_rd;

    always_comb begin
        o_full      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
        o_head.valid = (r_cnt != '0);
        o_head.item  = r_mem[r_rd_ptr];
        w_wr = i_wr_en && !o_full;
        w_rd = i_rd_en && o_head.valid;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

### sv/itp_back.sv
// back end: operator stack, pop sequencer and result output register
// depends on itp_pkg

`timescale 1ns / 1ps

module itp_back import itp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_head      i_head,
    output logic       o_rd_en,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_has_char,
    output logic       o_out_last_of_run,
    output logic [1:0] o_out_status
);

    logic [7:0]        r_stack [STACK_DEPTH];
    logic [CNT_W-1:0]  r_count;
    t_state            r_state;
    t_state            n_state;
    logic              r_any;

    t_result           r_hold_res;
    logic              r_hold_valid;
    logic              r_hold_fin;
    t_result           r_out_res;
    logic              r_out_valid;
    logic              r_out_last;
    t_result           n_hold_res;
    logic              n_hold_valid;
    logic              n_hold_fin;
    t_result           n_out_res;
    logic              n_out_valid;
    logic              n_out_last;

    logic [IDX_W-1:0]  w_top_addr;
    logic [7:0]        w_top;
    logic              w_empty;
    logic              w_full;
    logic              w_top_lp;
    logic              w_pop_op;
    logic              w_pop_rp;
    logic              w_out_free;
    logic              w_go;
    t_item             w_it;

    logic              g_emit;
    logic              g_end;
    t_result           g_res;
    logic              s_push;
    logic              s_pop;
    logic              s_clear;

    always_comb begin
        w_it       = i_head.item;
        w_top_addr = IDX_W'(r_count - CNT_W'(1));
        w_top      = r_stack[w_top_addr];
        w_empty    = (r_count == '0);
        w_full     = (r_count == CNT_W'(STACK_DEPTH));
        w_top_lp   = (w_top == CH_LPAREN);
        w_pop_rp   = !w_empty && !w_top_lp;
        w_pop_op   = w_pop_rp && (w_it.prec <= prec_of(w_top));
        w_out_free = !r_out_valid || !i_out_stall;
        w_go       = i_head.valid && !r_hold_fin && w_out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (w_go) begin
                    unique case (w_it.cls)
                        CL_LETTER: begin
                            if (w_it.eoi && !w_empty) begin
                                n_state = ST_FLUSH;
                            end
                        end
                        CL_RPAREN: begin
                            if (!w_pop_rp && !w_empty && w_it.eoi &&
                                (r_count != CNT_W'(1))) begin
                                n_state = ST_FLUSH;
                            end
                        end
                        default: begin
                            if (!(w_it.cls == CL_OPER && w_pop_op) && !w_full && w_it.eoi) begin
                                n_state = ST_FLUSH;
                            end
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (w_go && (r_count <= CNT_W'(1))) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // sequencer outputs
    always_comb begin
        g_emit     = 1'b0;
        g_end      = 1'b0;
        g_res.ch     = w_top;
        g_res.has    = 1'b1;
        g_res.status = STAT_OK;
        s_push     = 1'b0;
        s_pop      = 1'b0;
        s_clear    = 1'b0;
        if (w_go) begin
            unique case (r_state)
                ST_RUN: begin
                    unique case (w_it.cls)
                        CL_LETTER: begin
                            g_emit   = 1'b1;
                            g_res.ch = w_it.ch;
                            g_end    = !(w_it.eoi && !w_empty);
                        end
                        CL_RPAREN: begin
                            if (w_pop_rp) begin
                                g_emit = 1'b1;
                                s_pop  = 1'b1;
                            end else if (!w_empty) begin
                                s_pop = 1'b1;
                                g_end = !(w_it.eoi && (r_count != CNT_W'(1)));
                            end else begin
                                g_emit       = 1'b1;
                                g_res.ch     = CH_NONE;
                                g_res.has    = 1'b0;
                                g_res.status = STAT_UNMATCHED;
                                g_end        = 1'b1;
                            end
                        end
                        default: begin
                            if (w_it.cls == CL_OPER && w_pop_op) begin
                                g_emit = 1'b1;
                                s_pop  = 1'b1;
                            end else if (w_full) begin
                                g_emit       = 1'b1;
                                g_res.ch     = CH_NONE;
                                g_res.has    = 1'b0;
                                g_res.status = STAT_OVERFLOW;
                                s_clear      = 1'b1;
                                g_end        = 1'b1;
                            end else begin
                                s_push = 1'b1;
                                g_end  = !w_it.eoi;
                            end
                        end
                    endcase
                end
                ST_FLUSH: begin
                    if (!w_empty) begin
                        g_emit = 1'b1;
                        s_pop  = 1'b1;
                    end
                    g_end = (r_count <= CNT_W'(1));
                end
                default: begin
                    g_end = 1'b0;
                end
            endcase
            // bare end marker when a final item produced nothing
            if (g_end && w_it.eoi && !r_any && !g_emit) begin
                g_emit       = 1'b1;
                g_res.ch     = CH_NONE;
                g_res.has    = 1'b0;
                g_res.status = STAT_OK;
            end
        end
        o_rd_en = g_end;
    end

    // result routing: hold one result back until it is known whether it is the last
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_res    = r_out_res;
        n_out_last   = r_out_last;
        n_hold_valid = r_hold_valid;
        n_hold_fin   = r_hold_fin;
        n_hold_res   = r_hold_res;
        if (r_hold_fin) begin
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out_res    = r_hold_res;
                n_out_last   = 1'b1;
                n_hold_valid = 1'b0;
                n_hold_fin   = 1'b0;
            end
        end else if (g_emit) begin
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out_res   = r_hold_res;
                n_out_last  = 1'b0;
                n_hold_res  = g_res;
                n_hold_fin  = g_end;
            end else if (g_end) begin
                n_out_valid = 1'b1;
                n_out_res   = g_res;
                n_out_last  = 1'b1;
            end else begin
                n_hold_valid = 1'b1;
                n_hold_res   = g_res;
            end
        end else if (g_end && r_hold_valid) begin
            n_out_valid  = 1'b1;
            n_out_res    = r_hold_res;
            n_out_last   = 1'b1;
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_count      <= '0;
            r_any        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_hold_fin   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_any        <= g_end ? 1'b0 : (r_any | g_emit);
            r_hold_valid <= n_hold_valid;
            r_hold_fin   <= n_hold_fin;
            r_out_valid  <= n_out_valid;
            if (s_clear) begin
                r_count <= '0;
            end else if (s_push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (s_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_res <= n_hold_res;
        r_out_res  <= n_out_res;
        r_out_last <= n_out_last;
        if (s_push) begin
            r_stack[r_count[IDX_W-1:0]] <= w_it.ch;
        end
    end

    always_comb begin
        o_out_valid       = r_out_valid;
        o_out_char        = r_out_res.ch;
        o_out_has_char    = r_out_res.has;
        o_out_last_of_run = r_out_last;
        o_out_status      = r_out_res.status;
    end

endmodule

### verif/testbench.sv
// self-checking testbench for infix_to_postfix_converter: random valid/stall traffic
// on both channels, each output transaction checked against a built-in shunting-yard model
// depends on itp_pkg and infix_to_postfix_converter

`timescale 1ns / 1ps

module testbench;
    import itp_pkg::*;

    localparam int NUM_ITEMS      = 430;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoe;
    } t_infix_char;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
        t_status    status;
    } t_postfix_res;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_char = 8'h00;
    logic       in_end_of_expr = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       out_has_char;
    logic       out_last_of_run;
    logic [1:0] out_status;

    t_infix_char  pending_q[$];
    t_infix_char  seq_q[$];
    t_postfix_res exp_postfix_q[$];
    t_postfix_res step_results[$];

    logic [7:0]  op_stack_m[STACK_DEPTH];
    int          stack_cnt_m;

    int          total_items;
    int          accepted_cnt = 0;
    int          mismatch_cnt = 0;
    int          idle_cycles  = 0;
    int unsigned send_gap;
    int unsigned recv_gap;
    logic [9:0]  cycle_cnt = '0;
    t_infix_char nxt;
    t_postfix_res want;

    infix_to_postfix_converter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_in_char         (in_char),
        .i_in_end_of_expr  (in_end_of_expr),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_out_char        (out_char),
        .o_out_has_char    (out_has_char),
        .o_out_last_of_run (out_last_of_run),
        .o_out_status      (out_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1'b1;
    end

    // shunting-yard model
    function automatic int op_rank(input logic [7:0] c);
        case (c) inside
            CH_DOLLAR, CH_CARET: return int'(PREC_POW);
            CH_STAR, CH_SLASH:   return int'(PREC_MUL);
            CH_PLUS, CH_MINUS:   return int'(PREC_ADD);
            default:             return int'(PREC_NONE);
        endcase
    endfunction

    function automatic logic alpha_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic add_result(input logic [7:0] c, input logic has, input t_status st);
        t_postfix_res r;
        r.ch     = c;
        r.has    = has;
        r.last   = 1'b0;
        r.status = st;
        step_results.push_back(r);
    endtask

    task automatic push_operator(input logic [7:0] c);
        if (stack_cnt_m >= STACK_DEPTH) begin
            stack_cnt_m = 0;
            add_result(CH_NONE, 1'b0, STAT_OVERFLOW);
        end else begin
            op_stack_m[stack_cnt_m] = c;
            stack_cnt_m++;
        end
    endtask

    task automatic predict_postfix(input logic [7:0] c, input logic eoe);
        t_postfix_res r;
        int           rank;
        step_results.delete();
        if (alpha_char(c)) begin
            add_result(c, 1'b1, STAT_OK);
        end else if (c == CH_LPAREN) begin
            push_operator(c);
        end else if (c == CH_RPAREN) begin
            while (stack_cnt_m > 0 && op_stack_m[stack_cnt_m - 1] != CH_LPAREN) begin
                add_result(op_stack_m[stack_cnt_m - 1], 1'b1, STAT_OK);
                stack_cnt_m--;
            end
            if (stack_cnt_m > 0)
                stack_cnt_m--;
            else
                add_result(CH_NONE, 1'b0, STAT_UNMATCHED);
        end else begin
            rank = op_rank(c);
            while (stack_cnt_m > 0 && op_stack_m[stack_cnt_m - 1] != CH_LPAREN &&
                   rank <= op_rank(op_stack_m[stack_cnt_m - 1])) begin
                add_result(op_stack_m[stack_cnt_m - 1], 1'b1, STAT_OK);
                stack_cnt_m--;
            end
            push_operator(c);
        end
        if (eoe) begin
            while (stack_cnt_m > 0) begin
                add_result(op_stack_m[stack_cnt_m - 1], 1'b1, STAT_OK);
                stack_cnt_m--;
            end
            if (step_results.size() == 0)
                add_result(CH_NONE, 1'b0, STAT_OK);
        end
        for (int i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.last = (i == step_results.size() - 1);
            exp_postfix_q.push_back(r);
        end
    endtask

    // stimulus helpers
    task automatic add_item(input logic [7:0] c, input logic eoe);
        t_infix_char t;
        t.ch  = c;
        t.eoe = eoe;
        pending_q.push_back(t);
    endtask

    task automatic add_seq(input logic [7:0] c);
        t_infix_char t;
        t.ch  = c;
        t.eoe = 1'b0;
        seq_q.push_back(t);
    endtask

    task automatic flush_seq();
        for (int i = 0; i < seq_q.size(); i++)
            add_item(seq_q[i].ch, i == seq_q.size() - 1);
        seq_q.delete();
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(8'h41, 8'h5A));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] rand_operator();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0: c = CH_DOLLAR;
            1: c = CH_CARET;
            2: c = CH_STAR;
            3: c = CH_SLASH;
            4: c = CH_PLUS;
            5: c = CH_MINUS;
            default: begin
                do
                    c = 8'($urandom_range(0, 255));
                while (alpha_char(c) || c == CH_LPAREN || c == CH_RPAREN);
            end
        endcase
        return c;
    endfunction

    task automatic gen_expression();
        int n_opnd;
        int depth;
        n_opnd = $urandom_range(1, 8);
        depth  = 0;
        for (int k = 0; k < n_opnd; k++) begin
            while ($urandom_range(0, 3) == 0 && depth < 6) begin
                add_seq(CH_LPAREN);
                depth++;
            end
            add_seq(rand_letter());
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                add_seq(CH_RPAREN);
                depth--;
            end
            if (k != n_opnd - 1)
                add_seq(rand_operator());
        end
        if ($urandom_range(0, 4) != 0) begin
            while (depth > 0) begin
                add_seq(CH_RPAREN);
                depth--;
            end
        end
        flush_seq();
    endtask

    // nesting around the stack depth, overflow included
    task automatic gen_deep_nesting();
        int target;
        int pushed;
        target = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
        pushed = 0;
        while (pushed < target) begin
            add_seq(CH_LPAREN);
            pushed++;
            if (pushed < target && $urandom_range(0, 1)) begin
                add_seq(rand_operator());
                pushed++;
            end
        end
        add_seq(rand_letter());
        repeat ($urandom_range(0, 4)) add_seq(CH_RPAREN);
        add_seq(rand_letter());
        flush_seq();
    endtask

    task automatic gen_noise(input logic full_range);
        logic [7:0] c;
        repeat ($urandom_range(1, 6)) begin
            if (full_range) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                case ($urandom_range(0, 3))
                    0:       c = CH_LPAREN;
                    1:       c = CH_RPAREN;
                    2:       c = rand_letter();
                    default: c = rand_operator();
                endcase
            end
            add_item(c, $urandom_range(0, 3) == 0);
        end
    endtask

    function automatic int unsigned draw_wait(input logic quiet);
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // stimulus and end of run
    initial begin
        // A+z*(Z-a)/B^c$d
        add_item("A", 1'b0);
        add_item(CH_PLUS, 1'b0);
        add_item("z", 1'b0);
        add_item(CH_STAR, 1'b0);
        add_item(CH_LPAREN, 1'b0);
        add_item("Z", 1'b0);
        add_item(CH_MINUS, 1'b0);
        add_item("a", 1'b0);
        add_item(CH_RPAREN, 1'b0);
        add_item(CH_SLASH, 1'b0);
        add_item("B", 1'b0);
        add_item(CH_CARET, 1'b0);
        add_item("c", 1'b0);
        add_item(CH_DOLLAR, 1'b0);
        add_item("d", 1'b1);
        // unmatched close together with end
        add_item(CH_RPAREN, 1'b1);
        // end with nothing to emit
        add_item(CH_LPAREN, 1'b0);
        add_item(CH_RPAREN, 1'b1);
        // zero-precedence operators at the code extremes and midpoint
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h80, 1'b1);
        // unmatched close after popping an operator
        add_item("A", 1'b0);
        add_item(CH_MINUS, 1'b0);
        add_item(CH_RPAREN, 1'b0);
        add_item("q", 1'b1);

        while (pending_q.size() < NUM_ITEMS) begin
            case ($urandom_range(0, 19)) inside
                [0:12]:  gen_expression();
                13:      gen_deep_nesting();
                [14:16]: gen_noise(1'b1);
                default: gen_noise(1'b0);
            endcase
        end
        total_items = pending_q.size();

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        while (accepted_cnt != total_items || exp_postfix_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && exp_postfix_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_postfix(in_char, in_end_of_expr);
                accepted_cnt++;
                send_gap = draw_wait(cycle_cnt[7:6] == 2'd0);
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    nxt = pending_q.pop_front();
                    in_valid       <= 1'b1;
                    in_char        <= nxt.ch;
                    in_end_of_expr <= nxt.eoe;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (exp_postfix_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected transaction char %h has %b last %b status %0d",
                                 $realtime, out_char, out_has_char, out_last_of_run,
                                 out_status);
                end else begin
                    want = exp_postfix_q.pop_front();
                    if (out_char !== want.ch || out_has_char !== want.has ||
                        out_last_of_run !== want.last || out_status !== want.status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("%0t: mismatch exp char %h has %b last %b status %0d, %s",
                                     $realtime, want.ch, want.has, want.last, want.status,
                                     $sformatf("got char %h has %b last %b status %0d",
                                               out_char, out_has_char, out_last_of_run,
                                               out_status));
                    end
                end
                recv_gap = draw_wait(cycle_cnt[8:7] == 2'd1);
            end
            if (recv_gap > 0) begin
                out_stall <= 1'b1;
                recv_gap--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

### files.f
sv/itp_pkg.sv
sv/itp_front.sv
sv/itp_queue.sv
sv/itp_back.sv
sv/infix_to_postfix_converter.sv
verif/testbench.sv
